// File: rtl/vss_pkg.sv
// Package for the valve station sequencer: field widths, reset values and opcodes.
// No dependencies; used by valve_station_sequencer_unit.
package vss_pkg;

    localparam int STATION_COUNT_DEF = 4;

    localparam int TPM_W   = 17;
    localparam int MIN_W   = 10;
    localparam int OP_W    = 3;
    localparam int ST_W    = 3;
    localparam int MASK_W  = 4;
    localparam int PROG_N  = 4;

    localparam logic [TPM_W-1:0] TPM_RESET = 17'd60000;
    localparam logic [MIN_W-1:0] MIN_MAX   = 10'd1023;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK          = 3'd0,
        OP_START_PROGRAM = 3'd1,
        OP_START_STATION = 3'd2,
        OP_TOGGLE        = 3'd3,
        OP_STOP          = 3'd4,
        OP_CLEAR_ACTIVE  = 3'd5
    } op_t;

    localparam logic [2:0] STATUS_IDLE    = 3'd0;
    localparam logic [2:0] STATUS_PROGRAM = 3'd5;

endpackage

// File: rtl/valve_station_sequencer_unit.sv
// An input transfer goes through the input register and then the result register.
// Throughput: one item per cycle while m_tready is high; the two stages are these registers.
// A stalled result register holds the input register, which then holds s_tready low.
// Reset (aresetn low, synchronous) closes all valves, clears run state and run times,
// and sets ticks_per_minute to 60000. The configuration port is always ready.
// Depends on vss_pkg.
module valve_station_sequencer_unit #(
    parameter int STATION_COUNT = vss_pkg::STATION_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: ticks_per_minute
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vss_pkg::TPM_W-1:0]      cfg_data,
    // Input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: station[2:0], station_minutes[12:3], run_minutes_one[22:13],
    // run_minutes_two[32:23], run_minutes_three[42:33], run_minutes_four[52:43], zero fill.
    input  logic [vss_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: op[2:0].
    input  logic [vss_pkg::OP_W-1:0]       s_tuser,
    // Result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: valve_mask[3:0], master_valve[4], run_status[7:5],
    // active_station[10:8], activity_seen[11], zero fill.
    output logic [vss_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int SW  = (STATION_COUNT < 2) ? 1 : $clog2(STATION_COUNT + 1);
    localparam int IW  = (STATION_COUNT < 2) ? 1 : $clog2(STATION_COUNT);
    localparam int VW  = STATION_COUNT;
    localparam int VXW = (VW > vss_pkg::MASK_W) ? VW : vss_pkg::MASK_W;
    localparam int SXW = (SW > 3) ? SW : 3;
    localparam int MW  = vss_pkg::MIN_W;

    typedef logic [MW-1:0] minutes_t;

    // Configuration register
    logic [vss_pkg::TPM_W-1:0] tpm_reg;

    // Input register
    logic                      in_valid_reg;
    logic [vss_pkg::OP_W-1:0]  in_op_reg;
    logic [vss_pkg::ST_W-1:0]  in_station_reg;
    minutes_t                  in_minutes_reg;
    minutes_t                  in_prog_reg [vss_pkg::PROG_N];

    // Sequencer state
    minutes_t                  rt_reg [STATION_COUNT];
    minutes_t                  rt_next [STATION_COUNT];
    logic [SW-1:0]             cur_reg, cur_next;
    logic                      running_reg, running_next;
    logic                      prog_reg, prog_next;
    logic [VW-1:0]             valves_reg, valves_next;
    logic                      master_reg, master_next;
    logic [vss_pkg::TPM_W-1:0] tick_reg, tick_next;
    minutes_t                  min_reg, min_next;
    logic                      act_reg, act_next;

    // Result register
    logic                      out_valid_reg;
    logic [vss_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                      advance;
    logic                      in_xfer;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        logic [VW-1:0]             cur_bit;
        logic [VW-1:0]             st_bit;
        logic [SW-1:0]             st_num;
        logic                      st_ok;
        logic                      last_station;
        logic [IW-1:0]             cur_idx;
        logic [IW-1:0]             st_idx;
        logic [vss_pkg::TPM_W-1:0] tick_inc;
        minutes_t                  min_inc;
        minutes_t                  min_now;
        logic                      start_req;
        logic [VXW-1:0]            valves_ext;
        logic [SXW-1:0]            cur_ext;
        logic [2:0]                status;
        logic [2:0]                active;

        cur_next     = cur_reg;
        running_next = running_reg;
        prog_next    = prog_reg;
        valves_next  = valves_reg;
        master_next  = master_reg;
        tick_next    = tick_reg;
        min_next     = min_reg;
        act_next     = act_reg;
        for (int i = 0; i < STATION_COUNT; i++) begin
            rt_next[i] = rt_reg[i];
        end

        cur_bit      = VW'(1) << (cur_reg - SW'(1));
        st_num       = SW'(in_station_reg);
        st_ok        = (in_station_reg != '0) && (32'(in_station_reg) <= STATION_COUNT);
        st_bit       = VW'(1) << (st_num - SW'(1));
        last_station = (32'(cur_reg) >= STATION_COUNT);
        cur_idx      = IW'(cur_reg - SW'(1));
        st_idx       = IW'(st_num - SW'(1));
        tick_inc     = vss_pkg::TPM_W'(tick_reg + 1'b1);
        min_inc      = (min_reg == vss_pkg::MIN_MAX) ? min_reg : minutes_t'(min_reg + 1'b1);
        min_now      = min_reg;
        start_req    = 1'b0;

        unique case (in_op_reg)
            vss_pkg::OP_TICK: begin
                if (running_reg) begin
                    master_next = 1'b1;
                    if ((valves_reg & cur_bit) == '0) begin
                        // First tick of a station opens its valve and restarts the timer.
                        valves_next = valves_reg | cur_bit;
                        tick_next   = '0;
                        min_next    = '0;
                        act_next    = 1'b1;
                    end else begin
                        // A setting of zero compares as always reached, i.e. acts like one.
                        tick_next = tick_inc;
                        if (tick_inc >= tpm_reg) begin
                            tick_next = '0;
                            min_now   = min_inc;
                        end
                        min_next = min_now;
                        if (min_now >= rt_reg[cur_idx]) begin
                            if (!prog_reg || last_station) begin
                                cur_next     = '0;
                                running_next = 1'b0;
                                prog_next    = 1'b0;
                                valves_next  = '0;
                                master_next  = 1'b0;
                                tick_next    = '0;
                                min_next     = '0;
                            end else begin
                                valves_next = valves_reg & ~cur_bit;
                                cur_next    = SW'(cur_reg + 1'b1);
                                tick_next   = '0;
                                min_next    = '0;
                            end
                        end
                    end
                end
            end
            vss_pkg::OP_START_PROGRAM: begin
                for (int i = 0; i < STATION_COUNT; i++) begin
                    rt_next[i] = (i < vss_pkg::PROG_N) ? in_prog_reg[i[1:0]] : '0;
                end
                cur_next     = SW'(1);
                running_next = 1'b1;
                prog_next    = 1'b1;
                valves_next  = valves_reg & VW'(1);
                tick_next    = '0;
                min_next     = '0;
            end
            vss_pkg::OP_START_STATION: begin
                start_req = 1'b1;
            end
            vss_pkg::OP_TOGGLE: begin
                if (running_reg) begin
                    cur_next     = '0;
                    running_next = 1'b0;
                    prog_next    = 1'b0;
                    valves_next  = '0;
                    master_next  = 1'b0;
                    tick_next    = '0;
                    min_next     = '0;
                end else begin
                    start_req = 1'b1;
                end
            end
            vss_pkg::OP_STOP: begin
                cur_next     = '0;
                running_next = 1'b0;
                prog_next    = 1'b0;
                valves_next  = '0;
                master_next  = 1'b0;
                tick_next    = '0;
                min_next     = '0;
            end
            vss_pkg::OP_CLEAR_ACTIVE: begin
                act_next = 1'b0;
            end
            default: begin
            end
        endcase

        if (start_req && st_ok) begin
            rt_next[st_idx] = in_minutes_reg;
            cur_next        = st_num;
            running_next    = 1'b1;
            prog_next       = 1'b0;
            valves_next     = valves_reg & st_bit;
            tick_next       = '0;
            min_next        = '0;
        end

        valves_ext = VXW'(valves_next);
        cur_ext    = SXW'(cur_next);
        if (!running_next) begin
            status = vss_pkg::STATUS_IDLE;
        end else if (prog_next) begin
            status = vss_pkg::STATUS_PROGRAM;
        end else begin
            status = cur_ext[2:0];
        end
        active = running_next ? cur_ext[2:0] : 3'd0;

        out_data_next = {4'd0, act_next, active, status, master_next,
                         valves_ext[vss_pkg::MASK_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg       <= vss_pkg::TPM_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            running_reg   <= 1'b0;
            prog_reg      <= 1'b0;
            valves_reg    <= '0;
            master_reg    <= 1'b0;
            tick_reg      <= '0;
            min_reg       <= '0;
            act_reg       <= 1'b0;
            for (int i = 0; i < STATION_COUNT; i++) begin
                rt_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                tpm_reg <= cfg_data;
            end

            if (in_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (in_valid_reg && advance) begin
                out_valid_reg <= 1'b1;
                cur_reg       <= cur_next;
                running_reg   <= running_next;
                prog_reg      <= prog_next;
                valves_reg    <= valves_next;
                master_reg    <= master_next;
                tick_reg      <= tick_next;
                min_reg       <= min_next;
                act_reg       <= act_next;
                for (int i = 0; i < STATION_COUNT; i++) begin
                    rt_reg[i] <= rt_next[i];
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_op_reg      <= s_tuser;
            in_station_reg <= s_tdata[2:0];
            in_minutes_reg <= s_tdata[12:3];
            in_prog_reg[0] <= s_tdata[22:13];
            in_prog_reg[1] <= s_tdata[32:23];
            in_prog_reg[2] <= s_tdata[42:33];
            in_prog_reg[3] <= s_tdata[52:43];
        end
        if (in_valid_reg && advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // An idle sequencer has every valve closed and no current station.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (valves_reg == '0 && cur_reg == '0))
        else $error("idle sequencer holds an open valve or a station");

    // While running, the current station is a real one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (cur_reg != '0 && 32'(cur_reg) <= STATION_COUNT))
        else $error("running with a station out of range");

    // At most one station valve is open at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(valves_reg))
        else $error("more than one station valve open");

    // A station valve is never open without the master valve.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valves_reg != '0) |-> master_reg)
        else $error("station valve open with master closed");

    // A stalled result register freezes the sequencer state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=>
            ($stable(valves_reg) && $stable(cur_reg) && $stable(running_reg)))
        else $error("state moved while the result was stalled");

endmodule

// File: test/tb.sv
// Self-checking bench for valve_station_sequencer_unit: directed and random command streams,
// a cycle-free model of the sequencer and field-by-field checks of every result transfer.
// Depends on vss_pkg and the unit under test only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATIONS = vss_pkg::STATION_COUNT_DEF;

    typedef logic [vss_pkg::OP_W-1:0]  opcode_t;
    typedef logic [vss_pkg::ST_W-1:0]  station_t;
    typedef logic [vss_pkg::MIN_W-1:0] minutes_t;

    // Opcodes with no defined action; the unit only reports its state for them.
    localparam opcode_t OP_SPARE_LO = 3'd6;
    localparam opcode_t OP_SPARE_HI = 3'd7;

    typedef struct packed {
        opcode_t  op;
        station_t station;
        minutes_t station_minutes;
        minutes_t run_one;
        minutes_t run_two;
        minutes_t run_three;
        minutes_t run_four;
    } valve_cmd_t;

    // Same bit order as the low twelve bits of m_tdata.
    typedef struct packed {
        logic                       activity_seen;
        logic [2:0]                 active_station;
        logic [2:0]                 run_status;
        logic                       master_valve;
        logic [vss_pkg::MASK_W-1:0] valve_mask;
    } valve_report_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [vss_pkg::TPM_W-1:0]       cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [vss_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [vss_pkg::OP_W-1:0]        s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [vss_pkg::M_TDATA_W-1:0]   m_tdata;

    valve_station_sequencer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    valve_cmd_t    queued_commands[$];
    valve_report_t predicted_reports[$];
    valve_cmd_t    in_flight;
    valve_cmd_t    next_cmd;
    valve_report_t wanted;
    valve_report_t seen;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            error_count = 0;
    bit            cfg_request = 1'b0;
    logic [vss_pkg::TPM_W-1:0] cfg_value;

    // Model state of the sequencer.
    logic [vss_pkg::TPM_W-1:0]  tpm_q;
    minutes_t                   run_time_q [1:STATIONS];
    station_t                   cur_station;
    bit                         running_q;
    bit                         program_q;
    logic [vss_pkg::MASK_W-1:0] valves_q;
    bit                         master_q;
    logic [vss_pkg::TPM_W-1:0]  tick_q;
    minutes_t                   minute_q;
    bit                         activity_q;

    function automatic logic [vss_pkg::MASK_W-1:0] station_bit(input station_t s);
        if (s >= 1 && s <= STATIONS) begin
            return 4'b0001 << (s - 1);
        end
        return '0;
    endfunction

    function automatic void halt_watering();
        cur_station = '0;
        running_q   = 1'b0;
        program_q   = 1'b0;
        valves_q    = '0;
        master_q    = 1'b0;
        tick_q      = '0;
        minute_q    = '0;
    endfunction

    // A new run shuts every other station valve but leaves the master valve alone.
    function automatic void open_run(input station_t s, input bit prog);
        cur_station = s;
        running_q   = 1'b1;
        program_q   = prog;
        valves_q    = valves_q & station_bit(s);
        tick_q      = '0;
        minute_q    = '0;
    endfunction

    function automatic void start_station_run(input station_t s, input minutes_t mins);
        if (s >= 1 && s <= STATIONS) begin
            run_time_q[s] = mins;
            open_run(s, 1'b0);
        end
    endfunction

    function automatic valve_report_t advance_sequencer(input valve_cmd_t cmd);
        station_t                   s;
        logic [vss_pkg::MASK_W-1:0] b;
        valve_report_t              rpt;
        unique case (cmd.op)
            vss_pkg::OP_TICK: begin
                s = cur_station;
                if (running_q && s >= 1 && s <= STATIONS) begin
                    b = station_bit(s);
                    master_q = 1'b1;
                    if ((valves_q & b) == '0) begin
                        // The first tick of a run opens the valve, restarts the timer and marks activity.
                        valves_q   = valves_q | b;
                        tick_q     = '0;
                        minute_q   = '0;
                        activity_q = 1'b1;
                    end else begin
                        tick_q = tick_q + 1'b1;
                        if (tick_q >= tpm_q || tpm_q == '0) begin
                            tick_q = '0;
                            if (minute_q < vss_pkg::MIN_MAX) begin
                                minute_q = minute_q + 1'b1;
                            end
                        end
                        if (minute_q >= run_time_q[s]) begin
                            if (!program_q || s >= STATIONS) begin
                                halt_watering();
                            end else begin
                                valves_q    = valves_q & ~b;
                                cur_station = s + 1'b1;
                                tick_q      = '0;
                                minute_q    = '0;
                            end
                        end
                    end
                end
            end
            vss_pkg::OP_START_PROGRAM: begin
                run_time_q[1] = cmd.run_one;
                run_time_q[2] = cmd.run_two;
                run_time_q[3] = cmd.run_three;
                run_time_q[4] = cmd.run_four;
                open_run(3'd1, 1'b1);
            end
            vss_pkg::OP_START_STATION: begin
                start_station_run(cmd.station, cmd.station_minutes);
            end
            vss_pkg::OP_TOGGLE: begin
                if (running_q) begin
                    halt_watering();
                end else begin
                    start_station_run(cmd.station, cmd.station_minutes);
                end
            end
            vss_pkg::OP_STOP: begin
                halt_watering();
            end
            vss_pkg::OP_CLEAR_ACTIVE: begin
                activity_q = 1'b0;
            end
            default: begin
            end
        endcase
        rpt.valve_mask     = valves_q;
        rpt.master_valve   = master_q;
        rpt.run_status     = !running_q ? vss_pkg::STATUS_IDLE :
                             (program_q ? vss_pkg::STATUS_PROGRAM : cur_station);
        rpt.active_station = running_q ? cur_station : '0;
        rpt.activity_seen  = activity_q;
        return rpt;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Stimulus driver and configuration writer; the model follows the unit's reset.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            tpm_q = vss_pkg::TPM_RESET;
            for (int i = 1; i <= STATIONS; i++) begin
                run_time_q[i] = '0;
            end
            halt_watering();
            activity_q = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                tpm_q = cfg_data;
                cfg_valid <= 1'b0;
            end else if (cfg_request && !cfg_valid) begin
                cfg_valid <= 1'b1;
                cfg_data  <= cfg_value;
            end
            if (s_tvalid && s_tready) begin
                predicted_reports.push_back(advance_sequencer(in_flight));
            end
            if (!s_tvalid || s_tready) begin
                if (queued_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_cmd = queued_commands.pop_front();
                    in_flight <= next_cmd;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {3'b000, next_cmd.run_four, next_cmd.run_three,
                                  next_cmd.run_two, next_cmd.run_one,
                                  next_cmd.station_minutes, next_cmd.station};
                    s_tuser   <= next_cmd.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_reports.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    wanted = predicted_reports.pop_front();
                    seen   = m_tdata[11:0];
                    compare_field("valve_mask", 32'(wanted.valve_mask),
                                  32'(seen.valve_mask));
                    compare_field("master_valve", 32'(wanted.master_valve),
                                  32'(seen.master_valve));
                    compare_field("run_status", 32'(wanted.run_status),
                                  32'(seen.run_status));
                    compare_field("active_station", 32'(wanted.active_station),
                                  32'(seen.active_station));
                    compare_field("activity_seen", 32'(wanted.activity_seen),
                                  32'(seen.activity_seen));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic wait_for_drain();
        do @(negedge aclk);
        while (queued_commands.size() != 0 || s_tvalid || predicted_reports.size() != 0);
    endtask

    // The request is held until the driver raises cfg_valid, then the transfer is awaited.
    task automatic write_ticks_per_minute(input logic [vss_pkg::TPM_W-1:0] value);
        wait_for_drain();
        cfg_value   = value;
        cfg_request = 1'b1;
        do @(negedge aclk);
        while (!cfg_valid);
        cfg_request = 1'b0;
        do @(negedge aclk);
        while (cfg_valid);
    endtask

    function automatic void push_command(input opcode_t op, input station_t st,
                                         input minutes_t mins,
                                         input minutes_t r1, input minutes_t r2,
                                         input minutes_t r3, input minutes_t r4);
        valve_cmd_t cmd;
        cmd = '{op, st, mins, r1, r2, r3, r4};
        queued_commands.push_back(cmd);
    endfunction

    function automatic valve_cmd_t random_fill();
        valve_cmd_t cmd;
        cmd.op              = opcode_t'($urandom_range(vss_pkg::OP_TICK, OP_SPARE_HI));
        cmd.station         = station_t'($urandom_range(0, 7));
        cmd.station_minutes = minutes_t'($urandom_range(0, 1023));
        cmd.run_one         = minutes_t'($urandom_range(0, 1023));
        cmd.run_two         = minutes_t'($urandom_range(0, 1023));
        cmd.run_three       = minutes_t'($urandom_range(0, 1023));
        cmd.run_four        = minutes_t'($urandom_range(0, 1023));
        return cmd;
    endfunction

    // Mostly short runs so that programs finish; now and then a long one.
    function automatic minutes_t short_minutes();
        if ($urandom_range(0, 9) == 0) begin
            return minutes_t'($urandom_range(0, 1023));
        end
        return minutes_t'($urandom_range(0, 3));
    endfunction

    task automatic random_stimulus(input int count);
        int         pushed;
        int         pick;
        int         burst;
        valve_cmd_t cmd;
        pushed = 0;
        while (pushed < count) begin
            cmd  = random_fill();
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // A start of some kind, then a train of ticks to let the run play out.
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    cmd.op        = vss_pkg::OP_START_PROGRAM;
                    cmd.run_one   = short_minutes();
                    cmd.run_two   = short_minutes();
                    cmd.run_three = short_minutes();
                    cmd.run_four  = short_minutes();
                end else begin
                    cmd.op = (pick < 8) ? vss_pkg::OP_START_STATION : vss_pkg::OP_TOGGLE;
                    cmd.station = ($urandom_range(0, 6) == 0) ?
                                  station_t'($urandom_range(0, 7)) :
                                  station_t'($urandom_range(1, STATIONS));
                    cmd.station_minutes = short_minutes();
                end
                queued_commands.push_back(cmd);
                pushed++;
                burst = $urandom_range(1, 45);
                repeat (burst) begin
                    cmd    = random_fill();
                    cmd.op = vss_pkg::OP_TICK;
                    if ($urandom_range(0, 19) == 0) begin
                        cmd.op = opcode_t'($urandom_range(vss_pkg::OP_STOP, OP_SPARE_HI));
                    end
                    queued_commands.push_back(cmd);
                    pushed++;
                end
            end else if (pick == 7) begin
                cmd.op = $urandom_range(0, 1) ? vss_pkg::OP_STOP : vss_pkg::OP_TOGGLE;
                queued_commands.push_back(cmd);
                pushed++;
            end else begin
                queued_commands.push_back(cmd);
                pushed++;
            end
            // Now and then the sender holds back until every result is in.
            if ($urandom_range(0, 29) == 0) begin
                wait_for_drain();
            end
        end
    endtask

    initial begin
        send_idle_pct = 36;
        recv_idle_pct = 52;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, at the reset minute length.
        push_command(vss_pkg::OP_TICK, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_START_STATION, 3'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_START_STATION, 3'd7, 10'd5, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_TOGGLE, 3'd5, 10'd5, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_START_STATION, 3'd2, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_TICK, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_TICK, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_CLEAR_ACTIVE, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        // A program of zero-length runs walks through all four stations.
        push_command(vss_pkg::OP_START_PROGRAM, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        repeat (8) push_command(vss_pkg::OP_TICK, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_START_PROGRAM, 3'd7, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                     10'd1023);
        push_command(vss_pkg::OP_TICK, 3'd7, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        push_command(vss_pkg::OP_START_STATION, 3'd4, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                     10'd1023);
        push_command(vss_pkg::OP_TICK, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_TOGGLE, 3'd6, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(vss_pkg::OP_TOGGLE, 3'd4, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0);
        push_command(OP_SPARE_LO, 3'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
        push_command(OP_SPARE_HI, 3'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
        push_command(vss_pkg::OP_STOP, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);

        write_ticks_per_minute(17'd1);
        random_stimulus(450);
        write_ticks_per_minute(17'd3);
        random_stimulus(400);

        send_idle_pct = 52;
        recv_idle_pct = 36;
        // Zero behaves as one tick per minute.
        write_ticks_per_minute(17'd0);
        random_stimulus(350);
        write_ticks_per_minute(17'd131071);
        random_stimulus(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_ticks_per_minute(17'd2);
        random_stimulus(300);

        wait_for_drain();
        repeat (8) @(negedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
